// ===== sv/xorshift_range_pair_generator_assert.svh =====
// Assertion helpers used by the file that checks this block.
`ifndef XORSHIFT_RANGE_PAIR_GENERATOR_ASSERT_SVH
`define XORSHIFT_RANGE_PAIR_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define XRPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xrpg check failed");

// Next-cycle implication, disabled while reset is asserted.
`define XRPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xrpg check failed");

`endif

// ===== sv/xrpg_pkg.sv =====
package xrpg_pkg;

  localparam int VALUE_BITS = 32;
  localparam int WORD_BITS  = 64;
  localparam int REQ_TYPE_W = 2;

  localparam logic [WORD_BITS-1:0] RNG_SEED = 64'd88172645463325252;
  localparam int SHIFT_LEFT  = 7;
  localparam int SHIFT_RIGHT = 9;

  // One restoring step per dividend bit.
  localparam int DIV_STEPS = WORD_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [REQ_TYPE_W-1:0] REQ_RAW       = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_SINGLE    = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_ORDERED   = 2'd2;
  localparam logic [REQ_TYPE_W-1:0] REQ_UNORDERED = 2'd3;

  typedef struct packed {
    logic capture;
    logic step;
    logic div_start;
    logic div_second;
    logic save_a;
    logic save_b;
    logic load_out;
  } xrpg_cmd_t;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] kind;
    logic                  err;
    logic                  div_done;
    logic                  out_free;
  } xrpg_sts_t;

  function automatic logic [WORD_BITS-1:0] xs_next(input logic [WORD_BITS-1:0] s);
    logic [WORD_BITS-1:0] t;
    t = s ^ (s << SHIFT_LEFT);
    return t ^ (t >> SHIFT_RIGHT);
  endfunction

endpackage

// ===== sv/xrpg_req_if.sv =====
interface xrpg_req_if;
  import xrpg_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [REQ_TYPE_W-1:0]        req_type;
  logic signed [VALUE_BITS-1:0] range_low;
  logic signed [VALUE_BITS-1:0] range_high;

  modport source (output valid, output req_type, output range_low, output range_high,
                  input ready);
  modport sink (input valid, input req_type, input range_low, input range_high,
                output ready);
endinterface

// ===== sv/xrpg_rsp_if.sv =====
interface xrpg_rsp_if;
  import xrpg_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [WORD_BITS-1:0]         raw_word;
  logic signed [VALUE_BITS-1:0] first_value;
  logic signed [VALUE_BITS-1:0] second_value;
  logic                         status;

  modport source (output valid, output raw_word, output first_value, output second_value,
                  output status, input ready);
  modport sink (input valid, input raw_word, input first_value, input second_value,
                input status, output ready);
endinterface

// ===== sv/xrpg_dp.sv =====
module xrpg_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  xrpg_pkg::xrpg_cmd_t                   cmd,
  output xrpg_pkg::xrpg_sts_t                   sts,
  input  logic [xrpg_pkg::REQ_TYPE_W-1:0]       req_type,
  input  logic signed [xrpg_pkg::VALUE_BITS-1:0] range_low,
  input  logic signed [xrpg_pkg::VALUE_BITS-1:0] range_high,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [xrpg_pkg::WORD_BITS-1:0]        raw_word,
  output logic signed [xrpg_pkg::VALUE_BITS-1:0] first_value,
  output logic signed [xrpg_pkg::VALUE_BITS-1:0] second_value,
  output logic                                  status
);
  import xrpg_pkg::*;

  // Captured request.
  logic [REQ_TYPE_W-1:0]        kind_r;
  logic signed [VALUE_BITS-1:0] lo_r;
  logic signed [VALUE_BITS-1:0] hi_r;

  // Generator and working results.
  logic [WORD_BITS-1:0]  rng_r;
  logic [WORD_BITS-1:0]  word_nxt;
  logic [WORD_BITS-1:0]  raw_r;
  logic [VALUE_BITS-1:0] a_r;
  logic [VALUE_BITS-1:0] b_r;

  // Bit-serial remainder unit.
  logic [WORD_BITS-1:0]  dividend_r;
  logic [VALUE_BITS-1:0] divisor_r;
  logic [VALUE_BITS-1:0] rem_r;
  logic [VALUE_BITS-1:0] rem_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   trial_diff;
  logic [CNT_W-1:0]      cnt_r;

  // Range checks.
  logic [VALUE_BITS:0]   span_ext;
  logic [VALUE_BITS-1:0] span;
  logic                  range_empty;
  logic                  err;
  logic [VALUE_BITS-1:0] draw_val;
  logic [VALUE_BITS-1:0] bump_val;

  // Output register.
  logic                  out_valid_r;
  logic [WORD_BITS-1:0]  out_raw_r;
  logic [VALUE_BITS-1:0] out_a_r;
  logic [VALUE_BITS-1:0] out_b_r;
  logic                  out_status_r;

  assign span_ext    = {hi_r[VALUE_BITS-1], hi_r} - {lo_r[VALUE_BITS-1], lo_r};
  assign span        = span_ext[VALUE_BITS-1:0];
  assign range_empty = (hi_r <= lo_r);
  always_comb begin
    err = 1'b0;
    if (kind_r == REQ_SINGLE) begin
      err = range_empty;
    end else if (kind_r != REQ_RAW) begin
      err = range_empty || (span_ext < (VALUE_BITS + 1)'(2));
    end
  end

  assign word_nxt = xs_next(rng_r);

  assign trial      = {rem_r, dividend_r[WORD_BITS-1]};
  assign trial_diff = trial - {1'b0, divisor_r};
  assign rem_nxt    = trial_diff[VALUE_BITS] ? trial[VALUE_BITS-1:0]
                                             : trial_diff[VALUE_BITS-1:0];

  assign draw_val = rem_r + lo_r;
  assign bump_val = draw_val + VALUE_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= RNG_SEED;
      cnt_r <= '0;
    end else begin
      if (cmd.step) begin
        rng_r <= word_nxt;
      end
      if (cmd.div_start) begin
        cnt_r <= CNT_W'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= req_type;
      lo_r   <= range_low;
      hi_r   <= range_high;
      raw_r  <= '0;
      a_r    <= '0;
      b_r    <= '0;
    end
    if (cmd.step) begin
      raw_r <= word_nxt;
    end
    if (cmd.div_start) begin
      dividend_r <= word_nxt;
      rem_r      <= '0;
      divisor_r  <= cmd.div_second ? (span - VALUE_BITS'(1)) : span;
    end else if (cnt_r != '0) begin
      dividend_r <= dividend_r << 1;
      rem_r      <= rem_nxt;
    end
    if (cmd.save_a) begin
      a_r <= draw_val;
    end
    if (cmd.save_b) begin
      if ($signed(draw_val) >= $signed(a_r)) begin
        b_r <= bump_val;
      end else if (kind_r == REQ_ORDERED) begin
        a_r <= draw_val;
        b_r <= a_r;
      end else begin
        b_r <= draw_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_raw_r    <= raw_r;
      out_a_r      <= a_r;
      out_b_r      <= b_r;
      out_status_r <= err;
    end
  end

  assign sts.kind     = kind_r;
  assign sts.err      = err;
  assign sts.div_done = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign raw_word     = out_raw_r;
  assign first_value  = out_a_r;
  assign second_value = out_b_r;
  assign status       = out_status_r;

endmodule

// ===== sv/xrpg_ctrl.sv =====
module xrpg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  xrpg_pkg::xrpg_sts_t sts,
  output xrpg_pkg::xrpg_cmd_t cmd
);
  import xrpg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_DRAW2 = 3'd3;
  localparam logic [2:0] S_DIV2  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_START;
        end
      end
      S_START: begin
        if (sts.kind == REQ_RAW) begin
          cmd.step  = 1'b1;
          state_nxt = S_DONE;
        end else if (sts.err) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step      = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV1;
        end
      end
      S_DIV1: begin
        if (sts.div_done) begin
          cmd.save_a = 1'b1;
          state_nxt  = (sts.kind == REQ_SINGLE) ? S_DONE : S_DRAW2;
        end
      end
      S_DRAW2: begin
        cmd.step       = 1'b1;
        cmd.div_start  = 1'b1;
        cmd.div_second = 1'b1;
        state_nxt      = S_DIV2;
      end
      S_DIV2: begin
        if (sts.div_done) begin
          cmd.save_b = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/xorshift_range_pair_generator.sv =====
// Random range generator built on a 64-bit xorshift (shift left 7, then right 9), seeded
// at reset. Each request transfer carries a kind and a half-open range [low, high): kind 0
// returns one raw word, kind 1 one value in the range, kind 2 two distinct values in
// ascending order and kind 3 two distinct values in draw order; each request yields exactly
// one result transfer. A range too small for the request returns status 1 with all values
// zero and leaves the generator untouched. Requests are handled one at a time: a raw
// request only steps the generator, while a single draw or a pair runs one remainder pass
// per value drawn on the bit-serial remainder unit, which retires one dividend bit per cycle.
// A finished result sits in an output register, so a new request is accepted while the
// previous result still waits to be taken.
`include "xorshift_range_pair_generator_assert.svh"

module xorshift_range_pair_generator (
  input  logic        clk,
  input  logic        rst_n,
  xrpg_req_if.sink    in_req,
  xrpg_rsp_if.source  out_rsp
);
  import xrpg_pkg::*;

  // Command and status bundles between the controller and the datapath.
  xrpg_cmd_t cmd;
  xrpg_sts_t sts;

  // The controller sequences capture, generator steps, the remainder passes and the
  // hand-off to the output register.
  xrpg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the generator state, the remainder unit and the result registers.
  xrpg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (in_req.req_type),
    .range_low    (in_req.range_low),
    .range_high   (in_req.range_high),
    .out_valid    (out_rsp.valid),
    .out_ready    (out_rsp.ready),
    .raw_word     (out_rsp.raw_word),
    .first_value  (out_rsp.first_value),
    .second_value (out_rsp.second_value),
    .status       (out_rsp.status)
  );

  // A pending result is never overwritten by the next one.
  `XRPG_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.load_out, sts.out_free)
  // Only one request is in the block at a time.
  `XRPG_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready)
  // The generator only advances while the remainder unit is idle.
  `XRPG_ASSERT_NOW(a_step_when_idle, clk, rst_n, cmd.step, sts.div_done)
  // An error result carries all-zero values.
  `XRPG_ASSERT_NOW(a_err_zero, clk, rst_n, out_rsp.valid && out_rsp.status,
                   out_rsp.raw_word == '0 && out_rsp.first_value == '0 &&
                   out_rsp.second_value == '0)

endmodule
